/* rtl/core/adrc_pkg.sv */
// Package for the audio dynamic range compressor.
// Holds the configuration, command and status types, the state and opcode enums,
// and the constant functions that build the log2 and exp2 tables. No dependencies.
`default_nettype none

package adrc_pkg;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_EXPONENT  = 3'd1,
    REG_ATTACK    = 3'd2,
    REG_RELEASE   = 3'd3,
    REG_MAKEUP    = 3'd4
  } reg_idx_e;

  localparam logic [14:0] THRESHOLD_RESET = 15'd32767;
  localparam logic [15:0] MAKEUP_RESET    = 16'd4096;
  localparam logic [16:0] UNITY_GAIN      = 17'h10000;
  localparam logic [49:0] ROUND_BIAS      = 50'd32768;
  localparam logic [27:0] ROUND_HALF      = 28'h8000000;
  localparam logic [4:0]  MSB_START       = 5'd31;
  localparam logic [2:0]  NORM_LAST_STEP  = 3'd4;

  typedef struct packed {
    logic [14:0] threshold_level;
    logic [15:0] compress_exponent;
    logic [15:0] attack_coefficient;
    logic [15:0] release_coefficient;
    logic [15:0] post_gain;
  } cfg_t;

  // Micro-operations that the controller issues to the datapath.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ENV_M1,
    OP_ENV_M2,
    OP_ENV_W,
    OP_NORM_LD,
    OP_NORM_STEP,
    OP_LG_M1,
    OP_LG_T,
    OP_LG_M2,
    OP_LG_W,
    OP_D_M,
    OP_E_W,
    OP_EX_M1,
    OP_EX_T,
    OP_EX_M2,
    OP_EX_W,
    OP_UNITY,
    OP_G_M1,
    OP_G_M2,
    OP_G_W,
    OP_O_M1,
    OP_O_M2,
    OP_EMIT
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ENV_M1,
    S_ENV_M2,
    S_ENV_W,
    S_CHK,
    S_NORM_LD,
    S_NORM,
    S_LG_M1,
    S_LG_T,
    S_LG_M2,
    S_LG_W,
    S_D_M,
    S_E_W,
    S_EX_M1,
    S_EX_T,
    S_EX_M2,
    S_EX_W,
    S_UNITY,
    S_G_M1,
    S_G_M2,
    S_G_W,
    S_O_M1,
    S_O_M2,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e        op;
    logic       pass;  // 0: envelope log, 1: threshold log
    logic [2:0] step;  // normalizer step
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic above_thr;
    logic direct;
    logic out_busy;
  } status_t;

  // Bitwise square-and-compare log2 fraction of a Q1.16 mantissa.
  function automatic logic [15:0] bit_log2_frac(input logic [16:0] m);
    logic [35:0] y;
    logic [15:0] r;
    y = {19'd0, m};
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      y = (y * y) >> 16;
      if (y >= 36'd131072) begin
        y = y >> 1;
        r[b] = 1'b1;
      end
    end
    return r;
  endfunction

  // Largest mantissa whose log2 fraction does not exceed t.
  function automatic logic [17:0] exp_entry(input logic [15:0] t);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 65536;
    hi = 131071;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (bit_log2_frac(mid[16:0]) <= t) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return lo[17:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/audio_dynamic_range_compressor.sv */
// Top level of the audio dynamic range compressor.
// Instantiates adrc_regs, adrc_ctrl and adrc_dp; uses adrc_pkg types.
//
//   Channel   Direction  Signals                       Payload
//   s_axis    in         tvalid tready tdata tuser     sample_in, frame_start
//   m_axis    out        tvalid tready tdata           sample_out
//   apb       in/out     psel penable pwrite paddr ... register file, 5 registers
//
// The path from acceptance to output valid differs for bypass, below threshold, above
// it and the interpolated exp2 path; it is set by the one shared multiplier and the
// 5-step normalizer run for both envelope and threshold. The next sample is accepted
// once the result is registered.
// Reset sets registers to their defaults, the envelope to zero and the gain to unity.
// A stalled output holds the controller in its final state.
`default_nettype none

module audio_dynamic_range_compressor #(
  parameter int unsigned LOG_TABLE_ENTRIES = 64,
  parameter int unsigned EXP_TABLE_ENTRIES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
  input  wire logic        s_axis_tuser,   // [0] frame_start
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [15:0] m_axis_tdata,   // [15:0] sample_out
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  adrc_pkg::cfg_t    cfg;
  adrc_pkg::cmd_t    cmd;
  adrc_pkg::status_t status;

  // Configuration registers.
  adrc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer.
  adrc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Arithmetic and state.
  adrc_dp #(
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (s_axis_tdata),
    .frame_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // One sample in flight: acceptance drops ready on the next cycle.
  a_single_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a sample is in flight");

  // A result is written only into a free output register.
  a_emit_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == adrc_pkg::OP_EMIT |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending output transaction");

  // Samples are loaded only on an input transaction.
  a_load_on_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == adrc_pkg::OP_LOAD |-> s_axis_tvalid && s_axis_tready)
    else $error("sample loaded without an input transaction");

  // A result transaction appears in the cycle after the emit command.
  a_emit_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.op == adrc_pkg::OP_EMIT |=> m_axis_tvalid)
    else $error("emit did not raise output valid");

endmodule

`default_nettype wire

/* rtl/core/adrc_regs.sv */
// Configuration register file with an APB-style write and read port.
// Depends on adrc_pkg for the register indexes and the cfg_t type.
`default_nettype none

module adrc_regs (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output adrc_pkg::cfg_t     cfg_o
);

  adrc_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [2:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Register writes; indexes beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        adrc_pkg::REG_THRESHOLD: cfg_d.threshold_level     = pwdata[14:0];
        adrc_pkg::REG_EXPONENT:  cfg_d.compress_exponent   = pwdata[15:0];
        adrc_pkg::REG_ATTACK:    cfg_d.attack_coefficient  = pwdata[15:0];
        adrc_pkg::REG_RELEASE:   cfg_d.release_coefficient = pwdata[15:0];
        adrc_pkg::REG_MAKEUP:    cfg_d.post_gain           = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold_level     <= adrc_pkg::THRESHOLD_RESET;
      cfg_q.compress_exponent   <= '0;
      cfg_q.attack_coefficient  <= '0;
      cfg_q.release_coefficient <= '0;
      cfg_q.post_gain           <= adrc_pkg::MAKEUP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux.
  always_comb begin
    case (idx)
      adrc_pkg::REG_THRESHOLD: prdata = {17'd0, cfg_q.threshold_level};
      adrc_pkg::REG_EXPONENT:  prdata = {16'd0, cfg_q.compress_exponent};
      adrc_pkg::REG_ATTACK:    prdata = {16'd0, cfg_q.attack_coefficient};
      adrc_pkg::REG_RELEASE:   prdata = {16'd0, cfg_q.release_coefficient};
      adrc_pkg::REG_MAKEUP:    prdata = {16'd0, cfg_q.post_gain};
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* rtl/core/adrc_ctrl.sv */
// Controller state machine that sequences the compressor micro-operations.
// Depends on adrc_pkg for the state enum and the command and status structs.
`default_nettype none

module adrc_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  adrc_pkg::status_t     status_i,
  output adrc_pkg::cmd_t        cmd_o
);

  adrc_pkg::state_e state_q, state_d;
  logic             pass_q, pass_d;
  logic [2:0]       step_q, step_d;

  assign in_ready_o = (state_q == adrc_pkg::S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    step_d  = step_q;
    case (state_q)
      adrc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.bypass ? adrc_pkg::S_O_M1 : adrc_pkg::S_ENV_M1;
        end
      end
      adrc_pkg::S_ENV_M1: state_d = adrc_pkg::S_ENV_M2;
      adrc_pkg::S_ENV_M2: state_d = adrc_pkg::S_ENV_W;
      adrc_pkg::S_ENV_W:  state_d = adrc_pkg::S_CHK;
      adrc_pkg::S_CHK: begin
        pass_d  = 1'b0;
        state_d = status_i.above_thr ? adrc_pkg::S_NORM_LD : adrc_pkg::S_UNITY;
      end
      adrc_pkg::S_NORM_LD: begin
        step_d  = '0;
        state_d = adrc_pkg::S_NORM;
      end
      adrc_pkg::S_NORM: begin
        step_d = step_q + 3'd1;
        if (step_q == adrc_pkg::NORM_LAST_STEP) begin
          state_d = adrc_pkg::S_LG_M1;
        end
      end
      adrc_pkg::S_LG_M1: state_d = adrc_pkg::S_LG_T;
      adrc_pkg::S_LG_T:  state_d = adrc_pkg::S_LG_M2;
      adrc_pkg::S_LG_M2: state_d = adrc_pkg::S_LG_W;
      adrc_pkg::S_LG_W: begin
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = adrc_pkg::S_NORM_LD;
        end else begin
          state_d = adrc_pkg::S_D_M;
        end
      end
      adrc_pkg::S_D_M: state_d = adrc_pkg::S_E_W;
      adrc_pkg::S_E_W: begin
        state_d = status_i.direct ? adrc_pkg::S_G_M1 : adrc_pkg::S_EX_M1;
      end
      adrc_pkg::S_EX_M1: state_d = adrc_pkg::S_EX_T;
      adrc_pkg::S_EX_T:  state_d = adrc_pkg::S_EX_M2;
      adrc_pkg::S_EX_M2: state_d = adrc_pkg::S_EX_W;
      adrc_pkg::S_EX_W:  state_d = adrc_pkg::S_G_M1;
      adrc_pkg::S_UNITY: state_d = adrc_pkg::S_G_M1;
      adrc_pkg::S_G_M1:  state_d = adrc_pkg::S_G_M2;
      adrc_pkg::S_G_M2:  state_d = adrc_pkg::S_G_W;
      adrc_pkg::S_G_W:   state_d = adrc_pkg::S_O_M1;
      adrc_pkg::S_O_M1:  state_d = adrc_pkg::S_O_M2;
      adrc_pkg::S_O_M2:  state_d = adrc_pkg::S_OUT;
      adrc_pkg::S_OUT: begin
        if (!status_i.out_busy) begin
          state_d = adrc_pkg::S_IDLE;
        end
      end
      default: state_d = adrc_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o.pass = pass_q;
    cmd_o.step = step_q;
    case (state_q)
      adrc_pkg::S_IDLE:    cmd_o.op = in_valid_i ? adrc_pkg::OP_LOAD : adrc_pkg::OP_NONE;
      adrc_pkg::S_ENV_M1:  cmd_o.op = adrc_pkg::OP_ENV_M1;
      adrc_pkg::S_ENV_M2:  cmd_o.op = adrc_pkg::OP_ENV_M2;
      adrc_pkg::S_ENV_W:   cmd_o.op = adrc_pkg::OP_ENV_W;
      adrc_pkg::S_NORM_LD: cmd_o.op = adrc_pkg::OP_NORM_LD;
      adrc_pkg::S_NORM:    cmd_o.op = adrc_pkg::OP_NORM_STEP;
      adrc_pkg::S_LG_M1:   cmd_o.op = adrc_pkg::OP_LG_M1;
      adrc_pkg::S_LG_T:    cmd_o.op = adrc_pkg::OP_LG_T;
      adrc_pkg::S_LG_M2:   cmd_o.op = adrc_pkg::OP_LG_M2;
      adrc_pkg::S_LG_W:    cmd_o.op = adrc_pkg::OP_LG_W;
      adrc_pkg::S_D_M:     cmd_o.op = adrc_pkg::OP_D_M;
      adrc_pkg::S_E_W:     cmd_o.op = adrc_pkg::OP_E_W;
      adrc_pkg::S_EX_M1:   cmd_o.op = adrc_pkg::OP_EX_M1;
      adrc_pkg::S_EX_T:    cmd_o.op = adrc_pkg::OP_EX_T;
      adrc_pkg::S_EX_M2:   cmd_o.op = adrc_pkg::OP_EX_M2;
      adrc_pkg::S_EX_W:    cmd_o.op = adrc_pkg::OP_EX_W;
      adrc_pkg::S_UNITY:   cmd_o.op = adrc_pkg::OP_UNITY;
      adrc_pkg::S_G_M1:    cmd_o.op = adrc_pkg::OP_G_M1;
      adrc_pkg::S_G_M2:    cmd_o.op = adrc_pkg::OP_G_M2;
      adrc_pkg::S_G_W:     cmd_o.op = adrc_pkg::OP_G_W;
      adrc_pkg::S_O_M1:    cmd_o.op = adrc_pkg::OP_O_M1;
      adrc_pkg::S_O_M2:    cmd_o.op = adrc_pkg::OP_O_M2;
      adrc_pkg::S_OUT:     cmd_o.op = status_i.out_busy ? adrc_pkg::OP_NONE : adrc_pkg::OP_EMIT;
      default:             cmd_o.op = adrc_pkg::OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adrc_pkg::S_IDLE;
      pass_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/adrc_dp.sv */
// Datapath of the compressor: state registers, one shared multiplier, normalizer,
// constant log2/exp2 tables and the output register. Depends on adrc_pkg.
`default_nettype none

module adrc_dp #(
  parameter int unsigned LOG_TABLE_ENTRIES = 64,
  parameter int unsigned EXP_TABLE_ENTRIES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  adrc_pkg::cfg_t        cfg_i,
  input  adrc_pkg::cmd_t        cmd_i,
  output adrc_pkg::status_t     status_o,
  input  wire logic [15:0]      sample_i,
  input  wire logic             frame_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [15:0]      out_data_o
);

  localparam int unsigned LogIw = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int unsigned ExpIw = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam logic [LogIw-1:0] LogLast = LogIw'(LOG_TABLE_ENTRIES);
  localparam logic [ExpIw-1:0] ExpLast = ExpIw'(EXP_TABLE_ENTRIES);

  // Constant tables, built at elaboration.
  logic [17:0] log_tab [LOG_TABLE_ENTRIES+1];
  logic [17:0] exp_tab [EXP_TABLE_ENTRIES+1];

  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_log
    localparam int unsigned Frac = (g * 65536) / LOG_TABLE_ENTRIES;
    if (g == LOG_TABLE_ENTRIES) begin : g_last
      assign log_tab[g] = 18'd65536;
    end else begin : g_mid
      assign log_tab[g] = {2'b00, adrc_pkg::bit_log2_frac(17'(65536 + Frac))};
    end
  end

  for (genvar g = 0; g <= EXP_TABLE_ENTRIES; g++) begin : g_exp
    localparam int unsigned Frac = (g * 65536) / EXP_TABLE_ENTRIES;
    if (g == EXP_TABLE_ENTRIES) begin : g_last
      assign exp_tab[g] = 18'd131072;
    end else begin : g_mid
      assign exp_tab[g] = adrc_pkg::exp_entry(16'(Frac));
    end
  end

  // State and working registers.
  logic [31:0] env_q;
  logic [16:0] gain_q;
  logic [16:0] abs_q;
  logic        neg_q;
  logic        rise_q;
  logic [49:0] prod_q;
  logic [49:0] acc_q;
  logic [31:0] v_q;
  logic [4:0]  p_q;
  logic [15:0] fr_q;
  logic [17:0] t0_q, t1_q;
  logic [21:0] log_e_q, log_t_q;
  logic [4:0]  ip_q;
  logic [15:0] f_q;
  logic [16:0] target_q;
  logic [15:0] out_q;
  logic        out_valid_q;

  logic        bypass;
  logic [31:0] ax;
  logic [16:0] abs_in;
  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic        mul_en;
  logic [15:0] env_pole, g_pole;
  logic [17:0] diff;
  logic [49:0] sum;
  logic [5:0]  sh;
  logic        top_zero;
  logic [21:0] logv;
  logic signed [22:0] dd;
  logic [21:0] d;
  logic        ip_big;
  logic [17:0] ex_sum;
  logic [LogIw-1:0] lidx, lidx1;
  logic [ExpIw-1:0] eidx, eidx1;
  logic [20:0] rq;
  logic [21:0] rq1;
  logic        rup;
  logic [15:0] sat;

  assign bypass   = (cfg_i.threshold_level == '0) || (cfg_i.compress_exponent == '0);
  assign ax       = {abs_q[15:0], 16'd0} | {abs_q[16], 31'd0};
  assign abs_in   = sample_i[15] ? 17'(-$signed({sample_i[15], sample_i})) : {1'b0, sample_i};
  assign env_pole = rise_q ? cfg_i.attack_coefficient : cfg_i.release_coefficient;
  // Target and gain hold through both gain products, so the pole is chosen directly.
  assign g_pole   = (target_q < gain_q) ? cfg_i.attack_coefficient
                                        : cfg_i.release_coefficient;
  assign diff     = (t1_q >= t0_q) ? (t1_q - t0_q) : '0;
  assign sum      = acc_q + prod_q;
  assign ip_big   = prod_q[49:32] > 18'd16;

  // Status to the controller.
  assign status_o.bypass    = bypass;
  assign status_o.above_thr = env_q > {1'b0, cfg_i.threshold_level, 16'd0};
  assign status_o.direct    = ip_big || (prod_q[31:16] == '0);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      adrc_pkg::OP_ENV_M1: begin
        mul_a = {1'b0, env_q};
        mul_b = {1'b0, env_pole};
      end
      adrc_pkg::OP_ENV_M2: begin
        mul_a = {1'b0, ax};
        mul_b = adrc_pkg::UNITY_GAIN - {1'b0, env_pole};
      end
      adrc_pkg::OP_LG_M1: begin
        mul_a = {17'd0, v_q[30:15]};
        mul_b = 17'(LOG_TABLE_ENTRIES);
      end
      adrc_pkg::OP_LG_M2, adrc_pkg::OP_EX_M2: begin
        mul_a = {15'd0, diff};
        mul_b = {1'b0, fr_q};
      end
      adrc_pkg::OP_D_M: begin
        mul_a = {11'd0, d};
        mul_b = {1'b0, cfg_i.compress_exponent};
      end
      adrc_pkg::OP_EX_M1: begin
        mul_a = {16'd0, adrc_pkg::UNITY_GAIN - {1'b0, f_q}};
        mul_b = 17'(EXP_TABLE_ENTRIES);
      end
      adrc_pkg::OP_G_M1: begin
        mul_a = {16'd0, gain_q};
        mul_b = {1'b0, g_pole};
      end
      adrc_pkg::OP_G_M2: begin
        mul_a = {16'd0, target_q};
        mul_b = adrc_pkg::UNITY_GAIN - {1'b0, g_pole};
      end
      adrc_pkg::OP_O_M1: begin
        mul_a = {16'd0, abs_q};
        mul_b = bypass ? adrc_pkg::UNITY_GAIN : gain_q;
      end
      adrc_pkg::OP_O_M2: begin
        mul_a = prod_q[32:0];
        mul_b = {1'b0, cfg_i.post_gain};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Normalizer step, log sum, exponent difference and table indexes.
  always_comb begin
    sh       = 6'd16 >> cmd_i.step;
    top_zero = (v_q >> (6'd32 - sh)) == '0;
    logv     = {1'b0, p_q, 16'd0} + {4'd0, t0_q} + {4'd0, prod_q[33:16]};
    dd       = $signed({1'b0, log_e_q}) - $signed({1'b0, log_t_q});
    d        = dd[22] ? '0 : dd[21:0];
    ex_sum   = t0_q + prod_q[33:16];
    lidx     = prod_q[16 +: LogIw];
    lidx1    = (lidx >= LogLast) ? LogLast : lidx + LogIw'(1);
    eidx     = prod_q[16 +: ExpIw];
    eidx1    = (eidx >= ExpLast) ? ExpLast : eidx + ExpIw'(1);
  end

  // Round to nearest even and saturate the Q28 product magnitude.
  always_comb begin
    rq  = prod_q[48:28];
    rup = (prod_q[27:0] > adrc_pkg::ROUND_HALF) ||
          ((prod_q[27:0] == adrc_pkg::ROUND_HALF) && rq[0]);
    rq1 = {1'b0, rq} + {21'd0, rup};
    if (neg_q) begin
      sat = (rq1 > 22'd32768) ? 16'h8000 : 16'(-$signed(rq1));
    end else begin
      sat = (rq1 > 22'd32767) ? 16'h7fff : rq1[15:0];
    end
  end

  // Persistent state: envelope, gain and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q       <= '0;
      gain_q      <= adrc_pkg::UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == adrc_pkg::OP_LOAD && frame_i) begin
        env_q  <= '0;
        gain_q <= adrc_pkg::UNITY_GAIN;
      end
      if (cmd_i.op == adrc_pkg::OP_ENV_W) begin
        env_q <= sum[47:16];
      end
      if (cmd_i.op == adrc_pkg::OP_G_W) begin
        gain_q <= sum[32:16];
      end
      if (cmd_i.op == adrc_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      adrc_pkg::OP_LOAD: begin
        abs_q  <= abs_in;
        neg_q  <= sample_i[15];
        rise_q <= {abs_in[15:0], 16'd0} > (frame_i ? 32'd0 : env_q) || abs_in[16];
      end
      adrc_pkg::OP_ENV_M2, adrc_pkg::OP_G_M2: acc_q <= prod_q + adrc_pkg::ROUND_BIAS;
      adrc_pkg::OP_NORM_LD: begin
        v_q <= cmd_i.pass ? {1'b0, cfg_i.threshold_level, 16'd0} : env_q;
        p_q <= adrc_pkg::MSB_START;
      end
      adrc_pkg::OP_NORM_STEP: begin
        if (top_zero) begin
          v_q <= v_q << sh;
          p_q <= p_q - sh[4:0];
        end
      end
      adrc_pkg::OP_LG_T: begin
        fr_q <= prod_q[15:0];
        t0_q <= log_tab[lidx];
        t1_q <= log_tab[lidx1];
      end
      adrc_pkg::OP_EX_T: begin
        fr_q <= prod_q[15:0];
        t0_q <= exp_tab[eidx];
        t1_q <= exp_tab[eidx1];
      end
      adrc_pkg::OP_LG_W: begin
        if (cmd_i.pass) begin
          log_t_q <= logv;
        end else begin
          log_e_q <= logv;
        end
      end
      adrc_pkg::OP_E_W: begin
        ip_q <= prod_q[36:32];
        f_q  <= prod_q[31:16];
        if (ip_big) begin
          target_q <= '0;
        end else if (prod_q[31:16] == '0) begin
          target_q <= adrc_pkg::UNITY_GAIN >> prod_q[36:32];
        end
      end
      adrc_pkg::OP_EX_W:  target_q <= 17'(ex_sum >> (ip_q + 5'd1));
      adrc_pkg::OP_UNITY: target_q <= adrc_pkg::UNITY_GAIN;
      adrc_pkg::OP_EMIT:  out_q <= sat;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
